// ----- rtl/crg_pkg.sv -----
`timescale 1ns / 1ps

package crg_pkg;

	localparam logic [1:0] CMD_EVAL   = 2'd0;
	localparam logic [1:0] CMD_ADD    = 2'd1;
	localparam logic [1:0] CMD_REMOVE = 2'd2;

	localparam logic [15:0] MIN_RANGE = 16'd7;
	localparam logic [63:0] WHITE     = 64'hFFFF_FFFF_FFFF_FFFF;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [15:0] position;
		logic [15:0] red_in;
		logic [15:0] green_in;
		logic [15:0] blue_in;
		logic [15:0] alpha_in;
		logic [2:0]  stop_index;
	} req_t;

	typedef struct packed {
		logic [15:0] red_out;
		logic [15:0] green_out;
		logic [15:0] blue_out;
		logic [15:0] alpha_out;
		logic        status;
		logic [3:0]  stop_count;
	} rsp_t;

	// color: red 15..0, green 31..16, blue 47..32, alpha 63..48
	typedef struct packed {
		logic [15:0] pos;
		logic [63:0] color;
	} entry_t;

	typedef struct packed {
		logic [63:0] color_a;
		logic [63:0] color_b;
		logic [15:0] num;
		logic [15:0] den;
	} lerp_req_t;

	typedef struct packed {
		logic        done;
		logic [63:0] color;
	} lerp_rsp_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_EV_FIRST,
		ST_EV_LAST,
		ST_EV_SCAN,
		ST_EV_CHK,
		ST_EV_LERP,
		ST_INS_RD,
		ST_INS_CMP,
		ST_REM_MV,
		ST_DONE
	} crg_state_t;

	typedef enum logic [1:0] {
		LP_IDLE,
		LP_MUL,
		LP_DIV,
		LP_ADD
	} lerp_state_t;

endpackage

// ----- rtl/crg_table.sv -----
`timescale 1ns / 1ps

module crg_table #(
	parameter int DEPTH = 8,
	parameter int AW    = 3
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [AW-1:0]        waddr,
	input  crg_pkg::entry_t      wdata,
	input  logic [AW-1:0]        raddr,
	output crg_pkg::entry_t      rdata
);

	crg_pkg::entry_t mem [DEPTH];
	crg_pkg::entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- rtl/crg_lerp.sv -----
`timescale 1ns / 1ps

module crg_lerp (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  crg_pkg::lerp_req_t   req,
	output crg_pkg::lerp_rsp_t   rsp
);

	crg_pkg::lerp_state_t state_q, state_d;
	logic [3:0]  cnt_q;
	crg_pkg::lerp_req_t req_q;
	logic [3:0]  sign_q;
	logic [15:0] rem_q [4];
	logic [15:0] lo_q [4];

	logic [1:0]  lane;
	logic [15:0] ca, cb, mag;
	logic [31:0] prod;
	logic [16:0] trial [4];
	logic        fits [4];
	logic [63:0] color;

	assign lane = cnt_q[1:0];
	assign ca   = req_q.color_a[16*lane +: 16];
	assign cb   = req_q.color_b[16*lane +: 16];
	assign mag  = (cb < ca) ? (ca - cb) : (cb - ca);
	assign prod = mag * req_q.num;

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			trial[k] = {rem_q[k], lo_q[k][15]};
			fits[k]  = trial[k] >= {1'b0, req_q.den};
			color[16*k +: 16] = sign_q[k] ? (req_q.color_a[16*k +: 16] - lo_q[k])
				: (req_q.color_a[16*k +: 16] + lo_q[k]);
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			crg_pkg::LP_IDLE: if (start) state_d = crg_pkg::LP_MUL;
			crg_pkg::LP_MUL:  if (cnt_q == 4'd3) state_d = crg_pkg::LP_DIV;
			crg_pkg::LP_DIV:  if (cnt_q == 4'd15) state_d = crg_pkg::LP_ADD;
			crg_pkg::LP_ADD:  state_d = crg_pkg::LP_IDLE;
			default:          state_d = crg_pkg::LP_IDLE;
		endcase
	end

	always_comb begin
		rsp.done  = (state_q == crg_pkg::LP_ADD);
		rsp.color = color;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= crg_pkg::LP_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q != state_d) begin
				cnt_q <= '0;
			end else begin
				cnt_q <= cnt_q + 4'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			crg_pkg::LP_IDLE: begin
				if (start) req_q <= req;
			end
			crg_pkg::LP_MUL: begin
				sign_q[lane] <= cb < ca;
				rem_q[lane]  <= prod[31:16];
				lo_q[lane]   <= prod[15:0];
			end
			crg_pkg::LP_DIV: begin
				for (int k = 0; k < 4; k++) begin
					rem_q[k] <= fits[k] ? 16'(trial[k] - {1'b0, req_q.den}) : trial[k][15:0];
					lo_q[k]  <= {lo_q[k][14:0], fits[k]};
				end
			end
			default: ;
		endcase
	end

endmodule

// ----- rtl/color_gradient_ramp.sv -----
`timescale 1ns / 1ps

// Evaluate: checks the first and last stops, then scans the stops to bracket the position, then
//   interpolates (one shared 16x16 multiplier over four channels, then a 16-step restoring
//   divider) and loads the result; clamped and narrow cases leave early.
// Add: shifts stops up one slot at a time from the end until the new stop's slot is found.
//   Remove: shifts each later stop down one slot. Refusals and empty-table evaluates skip to DONE.
// One request in flight; reset clears the stop count and control state, not the table.
module color_gradient_ramp #(
	parameter int MAX_STOPS = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  crg_pkg::req_t req_data,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output crg_pkg::rsp_t rsp_data
);

	localparam int CW = $clog2(MAX_STOPS + 1);
	localparam int AW = $clog2(MAX_STOPS);

	crg_pkg::crg_state_t state_q, state_d;
	logic [CW-1:0] count_q;
	logic          rsp_valid_q;
	crg_pkg::rsp_t rsp_q;

	crg_pkg::req_t   req_q;
	crg_pkg::entry_t a_q, b_q;
	logic [63:0]     res_color_q;
	logic            status_q;
	logic [CW-1:0]   slot_q, i_q;
	logic [AW-1:0]   ptr_q, ptr_d;

	logic            we;
	logic [AW-1:0]   waddr;
	crg_pkg::entry_t wdata, rdata, new_entry;
	logic            lerp_start;
	crg_pkg::lerp_req_t lerp_req;
	crg_pkg::lerp_rsp_t lerp_rsp;

	logic            accept, rsp_load;
	logic [CW-1:0]   cnt_m1, slot_m1;
	logic [CW+2:0]   idx_w, n_w, idx_p1;
	logic [CW:0]     i_p1, i_p2;
	logic            full, bad_rm, req_status;
	logic [15:0]     t, range;
	logic            t_le_rd, t_ge_rd, ins_move, rem_more, narrow;
	logic [CW+3:0]   cnt_ext;

	assign accept     = req_valid && !req_stall;
	assign req_stall  = (state_q != crg_pkg::ST_IDLE);
	assign rsp_load   = (state_q == crg_pkg::ST_DONE) && (!rsp_valid_q || !rsp_stall);

	assign cnt_m1  = count_q - CW'(1);
	assign slot_m1 = slot_q - CW'(1);
	assign idx_w   = {CW'(0), req_data.stop_index};
	assign n_w     = {3'b000, count_q};
	assign idx_p1  = idx_w + (CW+3)'(1);
	assign i_p1    = {1'b0, i_q} + (CW+1)'(1);
	assign i_p2    = {1'b0, i_q} + (CW+1)'(2);
	assign full    = count_q >= CW'(MAX_STOPS);
	assign bad_rm  = (idx_w >= n_w) || (count_q <= CW'(2));

	always_comb begin
		case (req_data.cmd)
			crg_pkg::CMD_EVAL:   req_status = 1'b0;
			crg_pkg::CMD_ADD:    req_status = full;
			crg_pkg::CMD_REMOVE: req_status = bad_rm;
			default:             req_status = 1'b1;
		endcase
	end

	assign t        = req_q.position;
	assign range    = b_q.pos - a_q.pos;
	assign t_le_rd  = t <= rdata.pos;
	assign t_ge_rd  = t >= rdata.pos;
	assign ins_move = rdata.pos > t;
	assign rem_more = i_p1 < {1'b0, count_q};
	assign narrow   = range < crg_pkg::MIN_RANGE;

	assign new_entry.pos   = req_q.position;
	assign new_entry.color = {req_q.alpha_in, req_q.blue_in, req_q.green_in, req_q.red_in};

	assign lerp_req.color_a = a_q.color;
	assign lerp_req.color_b = b_q.color;
	assign lerp_req.num     = t - a_q.pos;
	assign lerp_req.den     = range;

	crg_table #(
		.DEPTH (MAX_STOPS),
		.AW    (AW)
	) u_table (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (ptr_d),
		.rdata (rdata)
	);

	crg_lerp u_lerp (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (lerp_start),
		.req    (lerp_req),
		.rsp    (lerp_rsp)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			crg_pkg::ST_IDLE: begin
				if (accept) begin
					case (req_data.cmd)
						crg_pkg::CMD_EVAL:
							state_d = (count_q == '0) ? crg_pkg::ST_DONE : crg_pkg::ST_EV_FIRST;
						crg_pkg::CMD_ADD:
							state_d = full ? crg_pkg::ST_DONE : crg_pkg::ST_INS_RD;
						crg_pkg::CMD_REMOVE:
							state_d = bad_rm ? crg_pkg::ST_DONE : crg_pkg::ST_REM_MV;
						default:
							state_d = crg_pkg::ST_DONE;
					endcase
				end
			end
			crg_pkg::ST_EV_FIRST: begin
				state_d = (count_q == CW'(1) || t_le_rd) ? crg_pkg::ST_DONE
					: crg_pkg::ST_EV_LAST;
			end
			crg_pkg::ST_EV_LAST: state_d = t_ge_rd ? crg_pkg::ST_DONE : crg_pkg::ST_EV_SCAN;
			crg_pkg::ST_EV_SCAN: if (t_le_rd) state_d = crg_pkg::ST_EV_CHK;
			crg_pkg::ST_EV_CHK:  state_d = narrow ? crg_pkg::ST_DONE : crg_pkg::ST_EV_LERP;
			crg_pkg::ST_EV_LERP: if (lerp_rsp.done) state_d = crg_pkg::ST_DONE;
			crg_pkg::ST_INS_RD:  state_d = (slot_q == '0) ? crg_pkg::ST_DONE : crg_pkg::ST_INS_CMP;
			crg_pkg::ST_INS_CMP: state_d = ins_move ? crg_pkg::ST_INS_RD : crg_pkg::ST_DONE;
			crg_pkg::ST_REM_MV:  if (!rem_more) state_d = crg_pkg::ST_DONE;
			crg_pkg::ST_DONE:    if (rsp_load) state_d = crg_pkg::ST_IDLE;
			default:             state_d = crg_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		ptr_d      = ptr_q;
		we         = 1'b0;
		waddr      = slot_q[AW-1:0];
		wdata      = new_entry;
		lerp_start = 1'b0;
		unique case (state_q)
			crg_pkg::ST_IDLE: begin
				if (accept) begin
					ptr_d = (req_data.cmd == crg_pkg::CMD_REMOVE) ? idx_p1[AW-1:0] : '0;
				end
			end
			crg_pkg::ST_EV_FIRST: ptr_d = cnt_m1[AW-1:0];
			crg_pkg::ST_EV_LAST:  ptr_d = AW'(1);
			crg_pkg::ST_EV_SCAN:  if (!t_le_rd) ptr_d = ptr_q + AW'(1);
			crg_pkg::ST_EV_CHK:   lerp_start = !narrow;
			crg_pkg::ST_INS_RD: begin
				if (slot_q == '0) begin
					we = 1'b1;
				end else begin
					ptr_d = slot_m1[AW-1:0];
				end
			end
			crg_pkg::ST_INS_CMP: begin
				we    = 1'b1;
				wdata = ins_move ? rdata : new_entry;
			end
			crg_pkg::ST_REM_MV: begin
				if (rem_more) begin
					we    = 1'b1;
					waddr = i_q[AW-1:0];
					wdata = rdata;
					ptr_d = i_p2[AW-1:0];
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= crg_pkg::ST_IDLE;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if ((state_q == crg_pkg::ST_INS_RD && slot_q == '0) ||
			    (state_q == crg_pkg::ST_INS_CMP && !ins_move)) begin
				count_q <= count_q + CW'(1);
			end else if (state_q == crg_pkg::ST_REM_MV && !rem_more) begin
				count_q <= cnt_m1;
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign cnt_ext = {4'b0000, count_q};

	always_ff @(posedge clk) begin
		ptr_q <= ptr_d;
		case (state_q)
			crg_pkg::ST_IDLE: begin
				if (accept) begin
					req_q       <= req_data;
					res_color_q <= (req_data.cmd == crg_pkg::CMD_EVAL && count_q == '0)
						? crg_pkg::WHITE : '0;
					status_q    <= req_status;
					slot_q      <= count_q;
					i_q         <= idx_w[CW-1:0];
				end
			end
			crg_pkg::ST_EV_FIRST: begin
				a_q <= rdata;
				if (count_q == CW'(1) || t_le_rd) res_color_q <= rdata.color;
			end
			crg_pkg::ST_EV_LAST: if (t_ge_rd) res_color_q <= rdata.color;
			crg_pkg::ST_EV_SCAN: begin
				if (t_le_rd) begin
					b_q <= rdata;
				end else begin
					a_q <= rdata;
				end
			end
			crg_pkg::ST_EV_CHK:  if (narrow) res_color_q <= a_q.color;
			crg_pkg::ST_EV_LERP: if (lerp_rsp.done) res_color_q <= lerp_rsp.color;
			crg_pkg::ST_INS_CMP: if (ins_move) slot_q <= slot_m1;
			crg_pkg::ST_REM_MV:  if (rem_more) i_q <= i_p1[CW-1:0];
			default: ;
		endcase
		if (rsp_load) begin
			rsp_q.red_out    <= res_color_q[15:0];
			rsp_q.green_out  <= res_color_q[31:16];
			rsp_q.blue_out   <= res_color_q[47:32];
			rsp_q.alpha_out  <= res_color_q[63:48];
			rsp_q.status     <= status_q;
			rsp_q.stop_count <= cnt_ext[3:0];
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

endmodule

// ----- tb/sv/tb_color_gradient_ramp.sv -----
`timescale 1ns / 1ps

module tb_color_gradient_ramp;
	import crg_pkg::*;

	localparam int STOPS = 8;
	localparam int RANDOM_ITEMS = 1525;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 60;
	localparam logic [1:0] CMD_UNKNOWN = 2'd3;

	typedef struct {
		req_t req;
		bit   known;
		rsp_t rsp;
	} step_t;

	logic clk;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req_data = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp_data;

	logic [15:0] ramp_pos [STOPS];
	logic [63:0] ramp_color [STOPS];
	int unsigned ramp_count = 0;
	rsp_t ramp_due [$];
	step_t script [$];
	bit calm = 1'b0;
	int errors = 0;
	int cycles = 0;
	int n_eval = 0, n_lerp = 0, n_narrow = 0, n_add = 0, n_remove = 0, n_refused = 0;
	int n_unknown = 0;

	color_gradient_ramp #(.MAX_STOPS(STOPS)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req_data(req_data),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp_data(rsp_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic logic [63:0] blend(input logic [63:0] ca, input logic [63:0] cb,
			input logic [15:0] num, input logic [15:0] den);
		logic [63:0] mix;
		longint a, b, n, d, v;
		mix = '0;
		n = num;
		d = den;
		for (int k = 0; k < 4; k++) begin
			a = ca[16*k +: 16];
			b = cb[16*k +: 16];
			v = a + ((b - a) * n) / d;
			if (v < 0)
				v = 0;
			if (v > 65535)
				v = 65535;
			mix[16*k +: 16] = v[15:0];
		end
		return mix;
	endfunction

	function automatic rsp_t predict_ramp(input req_t r);
		rsp_t o;
		logic [63:0] c;
		logic [15:0] span;
		int unsigned slot;
		o = '0;
		c = '0;
		case (r.cmd)
			CMD_EVAL: begin
				n_eval++;
				if (ramp_count == 0)
					c = WHITE;
				else if (ramp_count == 1 || r.position <= ramp_pos[0])
					c = ramp_color[0];
				else if (r.position >= ramp_pos[ramp_count - 1])
					c = ramp_color[ramp_count - 1];
				else begin
					for (int i = 0; i + 1 < ramp_count; i++) begin
						if (r.position >= ramp_pos[i] && r.position <= ramp_pos[i + 1]) begin
							span = ramp_pos[i + 1] - ramp_pos[i];
							if (span < MIN_RANGE) begin
								c = ramp_color[i];
								n_narrow++;
							end else begin
								c = blend(ramp_color[i], ramp_color[i + 1],
									r.position - ramp_pos[i], span);
								n_lerp++;
							end
							break;
						end
					end
				end
			end
			CMD_ADD: begin
				n_add++;
				if (ramp_count >= STOPS)
					o.status = 1'b1;
				else begin
					slot = ramp_count;
					while (slot > 0 && ramp_pos[slot - 1] > r.position) begin
						ramp_pos[slot] = ramp_pos[slot - 1];
						ramp_color[slot] = ramp_color[slot - 1];
						slot--;
					end
					ramp_pos[slot] = r.position;
					ramp_color[slot] = {r.alpha_in, r.blue_in, r.green_in, r.red_in};
					ramp_count++;
				end
			end
			CMD_REMOVE: begin
				n_remove++;
				if (r.stop_index >= ramp_count || ramp_count <= 2)
					o.status = 1'b1;
				else begin
					for (int i = r.stop_index; i + 1 < ramp_count; i++) begin
						ramp_pos[i] = ramp_pos[i + 1];
						ramp_color[i] = ramp_color[i + 1];
					end
					ramp_count--;
				end
			end
			default: begin
				n_unknown++;
				o.status = 1'b1;
			end
		endcase
		if (o.status)
			n_refused++;
		o.red_out = c[15:0];
		o.green_out = c[31:16];
		o.blue_out = c[47:32];
		o.alpha_out = c[63:48];
		o.stop_count = ramp_count[3:0];
		return o;
	endfunction

	function automatic req_t rq(input logic [1:0] cmd, input logic [15:0] pos,
			input logic [63:0] color, input logic [2:0] idx);
		req_t r;
		r.cmd = cmd;
		r.position = pos;
		r.red_in = color[15:0];
		r.green_in = color[31:16];
		r.blue_in = color[47:32];
		r.alpha_in = color[63:48];
		r.stop_index = idx;
		return r;
	endfunction

	function automatic rsp_t rs(input logic [63:0] color, input logic st, input logic [3:0] cnt);
		rsp_t o;
		o.red_out = color[15:0];
		o.green_out = color[31:16];
		o.blue_out = color[47:32];
		o.alpha_out = color[63:48];
		o.status = st;
		o.stop_count = cnt;
		return o;
	endfunction

	task automatic add_row(input req_t r, input bit known, input rsp_t o);
		script.insert(script.size(), step_t'{r, known, o});
	endtask

	task automatic queue_result(input rsp_t o);
		ramp_due.insert(ramp_due.size(), o);
	endtask

	function automatic logic [15:0] pick_channel();
		case ($urandom_range(7))
			0: return 16'h0000;
			1: return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	// bias toward existing stops so narrow pairs and equal positions show up
	function automatic logic [15:0] pick_position();
		logic [15:0] p;
		int unsigned k;
		p = 16'($urandom);
		k = (ramp_count == 0) ? 0 : $urandom_range(ramp_count - 1);
		case ($urandom_range(9))
			0: p = 16'h0000;
			1: p = 16'hFFFF;
			2, 3: if (ramp_count != 0)
				p = ramp_pos[k];
			4, 5: if (ramp_count != 0)
				p = ramp_pos[k] + 16'($urandom_range(7)) - 16'd3;
			default: ;
		endcase
		return p;
	endfunction

	function automatic req_t random_request();
		req_t r;
		int unsigned p;
		p = $urandom_range(99);
		if (p < 46)
			r.cmd = CMD_EVAL;
		else if (p < 72)
			r.cmd = CMD_ADD;
		else if (p < 96)
			r.cmd = CMD_REMOVE;
		else
			r.cmd = CMD_UNKNOWN;
		if (r.cmd == CMD_ADD && ramp_count == STOPS && $urandom_range(1) == 1)
			r.cmd = CMD_REMOVE;
		r.position = pick_position();
		r.red_in = pick_channel();
		r.green_in = pick_channel();
		r.blue_in = pick_channel();
		r.alpha_in = pick_channel();
		if (ramp_count != 0 && $urandom_range(3) != 0)
			r.stop_index = 3'($urandom_range(ramp_count - 1));
		else
			r.stop_index = 3'($urandom);
		return r;
	endfunction

	task automatic note_error(input string what);
		errors++;
		if (errors <= 10)
			$display("ERROR @%0t: %s", $realtime, what);
	endtask

	// returns at the edge where the request is taken
	task automatic offer(input req_t r);
		if (!calm && $urandom_range(99) < 17) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 48)) @(posedge clk);
		end
		req_valid <= 1'b1;
		req_data <= r;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
	endtask

	always @(posedge clk) begin
		rsp_stall <= !calm && ($urandom_range(99) < 17);
	end

	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (ramp_due.size() == 0)
				note_error($sformatf("unexpected result %p", rsp_data));
			else begin
				want = ramp_due.pop_front();
				if (rsp_data.red_out !== want.red_out || rsp_data.green_out !== want.green_out
						|| rsp_data.blue_out !== want.blue_out
						|| rsp_data.alpha_out !== want.alpha_out
						|| rsp_data.status !== want.status
						|| rsp_data.stop_count !== want.stop_count)
					note_error($sformatf(
						"want rgba %h %h %h %h st %0d cnt %0d, got %h %h %h %h st %0d cnt %0d",
						want.red_out, want.green_out, want.blue_out, want.alpha_out,
						want.status, want.stop_count, rsp_data.red_out, rsp_data.green_out,
						rsp_data.blue_out, rsp_data.alpha_out, rsp_data.status,
						rsp_data.stop_count));
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles, ramp_due.size());
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		rsp_t due;
		req_t r;
		add_row(rq(CMD_EVAL, 16'h0000, '0, 3'd0), 1'b1, rs(WHITE, 1'b0, 4'd0));
		add_row(rq(CMD_EVAL, 16'hFFFF, '0, 3'd0), 1'b1, rs(WHITE, 1'b0, 4'd0));
		add_row(rq(CMD_REMOVE, 16'h0000, '0, 3'd0), 1'b1, rs('0, 1'b1, 4'd0));
		add_row(rq(CMD_UNKNOWN, 16'h1111, '1, 3'd7), 1'b1, rs('0, 1'b1, 4'd0));
		add_row(rq(CMD_ADD, 16'h4000, 64'h0004_0003_0002_0001, 3'd0), 1'b1,
			rs('0, 1'b0, 4'd1));
		add_row(rq(CMD_EVAL, 16'h9000, '0, 3'd0), 1'b1,
			rs(64'h0004_0003_0002_0001, 1'b0, 4'd1));
		add_row(rq(CMD_ADD, 16'hC000, '1, 3'd0), 1'b1, rs('0, 1'b0, 4'd2));
		add_row(rq(CMD_REMOVE, 16'h0000, '0, 3'd0), 1'b1, rs('0, 1'b1, 4'd2));
		add_row(rq(CMD_EVAL, 16'h0000, '0, 3'd0), 1'b1,
			rs(64'h0004_0003_0002_0001, 1'b0, 4'd2));
		add_row(rq(CMD_EVAL, 16'hFFFF, '0, 3'd0), 1'b1, rs(WHITE, 1'b0, 4'd2));
		add_row(rq(CMD_EVAL, 16'h8000, '0, 3'd0), 1'b0, '0);
		add_row(rq(CMD_ADD, 16'h8000, '0, 3'd0), 1'b1, rs('0, 1'b0, 4'd3));
		add_row(rq(CMD_ADD, 16'h8003, 64'h1234_5678_9ABC_DEF0, 3'd0), 1'b1,
			rs('0, 1'b0, 4'd4));
		add_row(rq(CMD_EVAL, 16'h8002, '0, 3'd0), 1'b0, '0);
		add_row(rq(CMD_ADD, 16'h8000, 64'hAAAA_5555_AAAA_5555, 3'd0), 1'b1,
			rs('0, 1'b0, 4'd5));
		add_row(rq(CMD_EVAL, 16'h8000, '0, 3'd0), 1'b0, '0);
		add_row(rq(CMD_ADD, 16'h0000, 64'h8000_8000_8000_8000, 3'd0), 1'b1,
			rs('0, 1'b0, 4'd6));
		add_row(rq(CMD_ADD, 16'hFFFF, 64'h0001_0001_0001_0001, 3'd0), 1'b1,
			rs('0, 1'b0, 4'd7));
		add_row(rq(CMD_ADD, 16'h2000, 64'hFFFF_0000_FFFF_0000, 3'd0), 1'b1,
			rs('0, 1'b0, 4'd8));
		add_row(rq(CMD_ADD, 16'h3000, '1, 3'd0), 1'b1, rs('0, 1'b1, 4'd8));
		add_row(rq(CMD_EVAL, 16'h3000, '0, 3'd0), 1'b0, '0);
		add_row(rq(CMD_REMOVE, 16'h0000, '0, 3'd7), 1'b1, rs('0, 1'b0, 4'd7));
		add_row(rq(CMD_REMOVE, 16'h0000, '0, 3'd7), 1'b1, rs('0, 1'b1, 4'd7));
		add_row(rq(CMD_EVAL, 16'h1234, '0, 3'd0), 1'b0, '0);
		add_row(rq(CMD_UNKNOWN, 16'hFFFF, '1, 3'd0), 1'b1, rs('0, 1'b1, 4'd7));

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (script[i]) begin
			offer(script[i].req);
			due = predict_ramp(script[i].req);
			queue_result(script[i].known ? script[i].rsp : due);
		end

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			calm = (n >= 600 && n < 900);
			r = random_request();
			offer(r);
			queue_result(predict_ramp(r));
		end
		calm = 1'b0;
		req_valid <= 1'b0;

		while (ramp_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d requests: %0d evaluations (%0d interpolated, %0d narrow pairs),",
			n_eval + n_add + n_remove + n_unknown, n_eval, n_lerp, n_narrow);
		$display("  %0d adds, %0d removes, %0d unknown, %0d refused, %0d mismatches, %0d cycles",
			n_add, n_remove, n_unknown, n_refused, errors, cycles);
		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// ----- files.f -----
rtl/crg_pkg.sv
rtl/crg_table.sv
rtl/crg_lerp.sv
rtl/color_gradient_ramp.sv
tb/sv/tb_color_gradient_ramp.sv
